>>> hdl/tpp_pkg.sv
// shared types and constants for the text packet header parser
package tpp_pkg;

  // parser phase codes
  localparam logic [2:0] PH_TYPE     = 3'd0;
  localparam logic [2:0] PH_COUNT    = 3'd1;
  localparam logic [2:0] PH_NSCHK    = 3'd2;
  localparam logic [2:0] PH_NS       = 3'd3;
  localparam logic [2:0] PH_COMMA    = 3'd4;
  localparam logic [2:0] PH_ACKSTART = 3'd5;
  localparam logic [2:0] PH_ACK      = 3'd6;
  localparam logic [2:0] PH_DATA     = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;

  // binary packet types that carry an attachment count
  localparam logic [3:0] TYPE_BIN_EVENT = 4'd5;
  localparam logic [3:0] TYPE_BIN_ACK   = 4'd6;

  // saturation limits
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [30:0] ACK_MAX   = 31'h7FFF_FFFF;

  // one decoded header
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  pkt_kind;
    logic [15:0] attach_count;
    logic        has_namespace;
    logic [15:0] ns_start;
    logic [15:0] ns_length;
    logic        has_ack;
    logic [30:0] ack_value;
    logic [15:0] data_start;
  } hdr_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> hdl/tpp_decode.sv
// header phase machine: consumes one character per step and builds the header fields
module tpp_decode #(
  parameter int POS_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output tpp_pkg::hdr_result_t result_o
);
  import tpp_pkg::*;

  logic [2:0]           phase_r, phase_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [3:0]           type_r, type_nxt;
  logic [15:0]          count_r, count_nxt;
  logic [30:0]          ack_r, ack_nxt;
  logic [POS_WIDTH-1:0] ns_start_r, ns_start_nxt;
  logic [POS_WIDTH-1:0] ns_len_r, ns_len_nxt;
  logic [POS_WIDTH-1:0] data_pos_r, data_pos_nxt;
  logic                 ns_seen_r, ns_seen_nxt;
  logic                 ack_seen_r, ack_seen_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 bad_r, bad_nxt;

  logic                 digit;
  logic [3:0]           dval;
  logic [19:0]          count_ext, count_sum;
  logic [34:0]          ack_ext, ack_sum;
  logic                 count_ovf, ack_ovf;
  logic [15:0]          count_sat;
  logic [30:0]          ack_sat;
  logic [POS_WIDTH-1:0] pos_end;
  logic                 done;
  logic [POS_WIDTH-1:0] ns_len_fin, data_pos_fin;
  logic [31:0]          ns_start_w, ns_len_w, data_pos_w;

  // digit decode and times-ten accumulators with saturation
  assign digit     = is_digit(char_i);
  assign dval      = char_i[3:0];
  assign count_ext = 20'(count_r);
  assign count_sum = (count_ext << 3) + (count_ext << 1) + 20'(dval);
  assign count_ovf = count_sum > 20'(COUNT_MAX);
  assign count_sat = count_ovf ? COUNT_MAX : count_sum[15:0];
  assign ack_ext   = 35'(ack_r);
  assign ack_sum   = (ack_ext << 3) + (ack_ext << 1) + 35'(dval);
  assign ack_ovf   = ack_sum > 35'(ACK_MAX);
  assign ack_sat   = ack_ovf ? ACK_MAX : ack_sum[30:0];
  assign pos_end   = pos_r + POS_WIDTH'(1);

  // one character through the phase machine, falling through skipped phases
  always_comb begin
    phase_nxt    = phase_r;
    type_nxt     = type_r;
    count_nxt    = count_r;
    ack_nxt      = ack_r;
    ns_start_nxt = ns_start_r;
    ns_len_nxt   = ns_len_r;
    data_pos_nxt = data_pos_r;
    ns_seen_nxt  = ns_seen_r;
    ack_seen_nxt = ack_seen_r;
    ovf_nxt      = ovf_r;
    bad_nxt      = bad_r;
    done         = 1'b0;

    if (phase_nxt == PH_TYPE) begin
      if (digit) begin
        type_nxt  = dval;
        phase_nxt = (dval == TYPE_BIN_EVENT || dval == TYPE_BIN_ACK) ? PH_COUNT : PH_NSCHK;
      end else begin
        bad_nxt   = 1'b1;
        phase_nxt = PH_DATA;
      end
      done = 1'b1;
    end

    if (!done && phase_nxt == PH_COUNT) begin
      if (digit) begin
        count_nxt = count_sat;
        ovf_nxt   = ovf_r | count_ovf;
        done      = 1'b1;
      end else if (char_i == CH_DASH) begin
        phase_nxt = PH_NSCHK;
        done      = 1'b1;
      end else begin
        phase_nxt = PH_NSCHK;
      end
    end

    if (!done && phase_nxt == PH_NSCHK) begin
      if (char_i == CH_SLASH) begin
        ns_seen_nxt  = 1'b1;
        ns_start_nxt = pos_r;
        phase_nxt    = PH_NS;
        done         = 1'b1;
      end else begin
        phase_nxt = PH_COMMA;
      end
    end

    if (!done && phase_nxt == PH_NS) begin
      if (char_i == CH_COMMA || char_i == CH_LBRACK) begin
        ns_len_nxt = pos_r - ns_start_r;
        phase_nxt  = PH_COMMA;
      end else begin
        done = 1'b1;
      end
    end

    if (!done && phase_nxt == PH_COMMA) begin
      phase_nxt = PH_ACKSTART;
      if (char_i == CH_COMMA) begin
        done = 1'b1;
      end
    end

    if (!done && (phase_nxt == PH_ACKSTART || phase_nxt == PH_ACK)) begin
      if (digit) begin
        ack_seen_nxt = 1'b1;
        ack_nxt      = ack_sat;
        ovf_nxt      = ovf_nxt | ack_ovf;
        phase_nxt    = PH_ACK;
      end else begin
        data_pos_nxt = pos_r;
        phase_nxt    = PH_DATA;
      end
    end
  end

  // close open fields at the end of the packet
  assign ns_len_fin   = (phase_nxt == PH_NS) ? (pos_end - ns_start_nxt) : ns_len_nxt;
  assign data_pos_fin = (phase_nxt != PH_DATA) ? pos_end : data_pos_nxt;
  assign ns_start_w   = 32'(ns_start_nxt);
  assign ns_len_w     = 32'(ns_len_fin);
  assign data_pos_w   = 32'(data_pos_fin);

  // result word, meaningful on the step that carries the last character
  always_comb begin
    result_o = '0;
    if (bad_nxt) begin
      result_o.status = ST_BAD_TYPE;
    end else begin
      result_o.status        = ovf_nxt ? ST_OVERFLOW : ST_OK;
      result_o.pkt_kind      = type_nxt;
      result_o.attach_count  = count_nxt;
      result_o.has_namespace = ns_seen_nxt;
      result_o.ns_start      = ns_start_w[15:0];
      result_o.ns_length     = ns_len_w[15:0];
      result_o.has_ack       = ack_seen_nxt;
      result_o.ack_value     = ack_nxt;
      result_o.data_start    = data_pos_w[15:0];
    end
  end

  // parser state, cleared after each packet
  always_ff @(posedge clk) begin
    if (!rst_n || (step_i && last_i)) begin
      phase_r    <= PH_TYPE;
      pos_r      <= '0;
      type_r     <= '0;
      count_r    <= '0;
      ack_r      <= '0;
      ns_start_r <= '0;
      ns_len_r   <= '0;
      data_pos_r <= '0;
      ns_seen_r  <= 1'b0;
      ack_seen_r <= 1'b0;
      ovf_r      <= 1'b0;
      bad_r      <= 1'b0;
    end else if (step_i) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      type_r     <= type_nxt;
      count_r    <= count_nxt;
      ack_r      <= ack_nxt;
      ns_start_r <= ns_start_nxt;
      ns_len_r   <= ns_len_nxt;
      data_pos_r <= data_pos_nxt;
      ns_seen_r  <= ns_seen_nxt;
      ack_seen_r <= ack_seen_nxt;
      ovf_r      <= ovf_nxt;
      bad_r      <= bad_nxt;
    end
  end

  assign pos_nxt = pos_end;

endmodule

>>> hdl/text_packet_header_parser.sv
// top level: streaming header parser for text event packets
//
// The input channel takes one packet character per word (in_char_in) with
// in_last_char marking the final character. Every word goes into an input
// register, from which the phase machine consumes it. Words that are
// not the last character produce nothing on the output channel. The last
// character produces exactly one output word carrying every header field.
// Throughput is one character per cycle; the phase machine and the
// times-ten accumulators are combinational, so nothing limits it
// below that except output backpressure.
// A last character passes through the input register and the output
// register to the out_ ports, where its word is held until taken.
// If the receiver stalls, the output register holds its word; the input
// register keeps taking non-final characters, and a final character waits
// in the input register until the output word is taken and leaves in the
// same cycle. Reset (rst_n low, synchronous) empties both registers and
// returns the parser to expecting a type digit at position zero.
module text_packet_header_parser #(
  parameter int POS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_pkt_kind,
  output logic [15:0] out_attach_count,
  output logic        out_has_namespace,
  output logic [15:0] out_ns_start,
  output logic [15:0] out_ns_length,
  output logic        out_has_ack,
  output logic [30:0] out_ack_value,
  output logic [15:0] out_data_start
);
  import tpp_pkg::*;

  logic        stg_valid_r;
  logic [7:0]  stg_char_r;
  logic        stg_last_r;
  logic        out_valid_r;
  hdr_result_t out_res_r;
  hdr_result_t result;
  logic        out_free;
  logic        stg_go;

  // handshake between input register, parser and output register
  assign out_free = !out_valid_r || out_ready;
  assign stg_go   = stg_valid_r && (!stg_last_r || out_free);
  assign in_ready = !stg_valid_r || stg_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_char_r <= in_char_in;
      stg_last_r <= in_last_char;
    end
  end

  tpp_decode #(
    .POS_WIDTH(POS_WIDTH)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (stg_go),
    .char_i  (stg_char_r),
    .last_i  (stg_last_r),
    .result_o(result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_go && stg_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && stg_last_r) begin
      out_res_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_pkt_kind      = out_res_r.pkt_kind;
  assign out_attach_count  = out_res_r.attach_count;
  assign out_has_namespace = out_res_r.has_namespace;
  assign out_ns_start      = out_res_r.ns_start;
  assign out_ns_length     = out_res_r.ns_length;
  assign out_has_ack       = out_res_r.has_ack;
  assign out_ack_value     = out_res_r.ack_value;
  assign out_data_start    = out_res_r.data_start;

endmodule
